[hdl/matrix3x3_inverse_assert.svh]
// Assertion macros for the 3x3 matrix inverse block.
// Included by the top level; no other dependencies.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("matrix3x3_inverse: implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("matrix3x3_inverse: next-cycle check failed");
`else
`define MI3_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MI3_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/mi3_pkg.sv]
// Shared types, widths, index tables and helpers for the 3x3 matrix inverse.
// No dependencies.
`timescale 1ns / 1ps
package mi3_pkg;

    localparam int ENT_W  = 32;             // Q16.16 entry
    localparam int N_ENT  = 9;
    localparam int N_DET  = 6;              // Sarrus terms
    localparam int PROD_W = 2 * ENT_W;      // pair product
    localparam int ADJ_W  = PROD_W + 1;     // difference of two products
    localparam int AMAG_W = PROD_W;         // adjugate magnitude
    localparam int SHF_W  = 32;             // numerator scale
    localparam int NUM_W  = AMAG_W + SHF_W;
    localparam int DET_W  = 97;             // signed determinant
    localparam int DMAG_W = DET_W - 1;
    localparam int QUO_W  = 33;             // quotient bits kept
    localparam int CMP_W  = DMAG_W + QUO_W;

    typedef logic signed [ENT_W-1:0] ent_t;
    typedef ent_t [N_ENT-1:0] mat_t;

    typedef struct packed {
        ent_t m00; ent_t m01; ent_t m02;
        ent_t m10; ent_t m11; ent_t m12;
        ent_t m20; ent_t m21; ent_t m22;
    } in_t;

    typedef struct packed {
        ent_t r00; ent_t r01; ent_t r02;
        ent_t r10; ent_t r11; ent_t r12;
        ent_t r20; ent_t r21; ent_t r22;
        logic singular;
        logic saturated;
    } out_t;

    // Handoff from the front end to the divider.
    typedef struct packed {
        logic                          valid;
        mat_t                          orig;
        logic                          zero;
        logic                          dneg;
        logic [N_ENT-1:0]              aneg;
        logic [N_ENT-1:0][AMAG_W-1:0]  amag;
        logic [DMAG_W-1:0]             dmag;
    } front_t;

    // One stage of the pipelined divider.
    typedef struct packed {
        logic                          valid;
        mat_t                          orig;
        logic                          zero;
        logic                          dneg;
        logic [N_ENT-1:0]              aneg;
        logic [N_ENT-1:0]              ovf;
        logic [DMAG_W-1:0]             dmag;
        logic [N_ENT-1:0][NUM_W-1:0]   rem;
        logic [N_ENT-1:0][QUO_W-1:0]   quo;
    } dstage_t;

    // Row-major entry positions of the six Sarrus terms.
    localparam int DET_IDX [N_DET][3] = '{
        '{0, 4, 8}, '{3, 7, 2}, '{6, 1, 5}, '{0, 7, 5}, '{6, 4, 2}, '{3, 1, 8}
    };
    // Adjugate entry k is a*b - c*d over these positions.
    localparam int ADJ_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    function automatic mat_t in_to_mat(input in_t d);
        mat_t m;
        m[0] = d.m00; m[1] = d.m01; m[2] = d.m02;
        m[3] = d.m10; m[4] = d.m11; m[5] = d.m12;
        m[6] = d.m20; m[7] = d.m21; m[8] = d.m22;
        return m;
    endfunction

endpackage

[hdl/mi3_front.sv]
// Front end: products, adjugate and determinant over seven register stages.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  mi3_pkg::in_t    in_data,
    output mi3_pkg::front_t out
);
    import mi3_pkg::*;

    logic [6:0] v_reg;
    mat_t       o1_reg, o2_reg, o3_reg, o4_reg, o5_reg, o6_reg, o7_reg;
    mat_t       mm;

    logic signed [PROD_W-1:0] dp_reg [N_DET];
    ent_t                     dc_reg [N_DET];
    logic signed [PROD_W-1:0] apa_reg [N_ENT];
    logic signed [PROD_W-1:0] apb_reg [N_ENT];

    logic signed [PROD_W-1:0] hi_reg [N_DET];
    logic signed [PROD_W:0]   lo_reg [N_DET];
    logic signed [ADJ_W-1:0]  adj_reg [N_ENT];

    logic signed [DET_W-1:0]  t_reg [N_DET];
    logic [N_ENT-1:0]         an3_reg, an4_reg, an5_reg, an6_reg, an7_reg;
    logic [N_ENT-1:0][AMAG_W-1:0] am3_reg, am4_reg, am5_reg, am6_reg, am7_reg;

    logic signed [DET_W-1:0]  s_reg [3];
    logic signed [DET_W-1:0]  s01_reg, s2_reg, det_reg;
    logic [DMAG_W-1:0]        dmag_reg;
    logic                     zero_reg, dneg_reg;

    logic signed [ADJ_W-1:0]  adj_abs [N_ENT];

    assign mm = in_to_mat(in_data);

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            adj_abs[k] = adj_reg[k][ADJ_W-1] ? -adj_reg[k] : adj_reg[k];
        end
    end

    // Stage pipeline of the arithmetic.
    always_ff @(posedge aclk) begin
        if (en) begin
            // Pair products.
            o1_reg <= mm;
            for (int k = 0; k < N_DET; k++) begin
                dp_reg[k] <= mm[DET_IDX[k][0]] * mm[DET_IDX[k][1]];
                dc_reg[k] <= mm[DET_IDX[k][2]];
            end
            for (int k = 0; k < N_ENT; k++) begin
                apa_reg[k] <= mm[ADJ_IDX[k][0]] * mm[ADJ_IDX[k][1]];
                apb_reg[k] <= mm[ADJ_IDX[k][2]] * mm[ADJ_IDX[k][3]];
            end
            // Triple products as two 32-bit partial products; adjugate difference.
            o2_reg <= o1_reg;
            for (int k = 0; k < N_DET; k++) begin
                hi_reg[k] <= $signed(dp_reg[k][PROD_W-1:ENT_W]) * dc_reg[k];
                lo_reg[k] <= $signed({1'b0, dp_reg[k][ENT_W-1:0]}) * dc_reg[k];
            end
            for (int k = 0; k < N_ENT; k++) begin
                adj_reg[k] <= apa_reg[k] - apb_reg[k];
            end
            // Recombine partial products; adjugate sign and magnitude.
            o3_reg <= o2_reg;
            for (int k = 0; k < N_DET; k++) begin
                t_reg[k] <= $signed({hi_reg[k][PROD_W-1], hi_reg[k], {ENT_W{1'b0}}})
                          + $signed({{(DET_W-PROD_W-1){lo_reg[k][PROD_W]}}, lo_reg[k]});
            end
            for (int k = 0; k < N_ENT; k++) begin
                an3_reg[k] <= adj_reg[k][ADJ_W-1];
                am3_reg[k] <= adj_abs[k][AMAG_W-1:0];
            end
            // Positive minus negative Sarrus terms.
            o4_reg  <= o3_reg;
            an4_reg <= an3_reg;
            am4_reg <= am3_reg;
            for (int k = 0; k < 3; k++) begin
                s_reg[k] <= t_reg[k] - t_reg[k+3];
            end
            // Determinant sum over two stages.
            o5_reg  <= o4_reg;
            an5_reg <= an4_reg;
            am5_reg <= am4_reg;
            s01_reg <= s_reg[0] + s_reg[1];
            s2_reg  <= s_reg[2];
            o6_reg  <= o5_reg;
            an6_reg <= an5_reg;
            am6_reg <= am5_reg;
            det_reg <= s01_reg + s2_reg;
            // Determinant sign, magnitude and zero test.
            o7_reg   <= o6_reg;
            an7_reg  <= an6_reg;
            am7_reg  <= am6_reg;
            dneg_reg <= det_reg[DET_W-1];
            zero_reg <= (det_reg == '0);
            dmag_reg <= det_reg[DET_W-1] ? DMAG_W'(-det_reg) : DMAG_W'(det_reg);
        end
    end

    assign out.valid = v_reg[6];
    assign out.orig  = o7_reg;
    assign out.zero  = zero_reg;
    assign out.dneg  = dneg_reg;
    assign out.aneg  = an7_reg;
    assign out.amag  = am7_reg;
    assign out.dmag  = dmag_reg;

endmodule

[hdl/mi3_div.sv]
// Pipelined restoring divider for nine quotients, one quotient bit per stage.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  mi3_pkg::front_t  in,
    output mi3_pkg::dstage_t out
);
    import mi3_pkg::*;

    dstage_t st_reg  [QUO_W+1];
    dstage_t st_next [QUO_W+1];

    // Entry stage: numerator is the magnitude scaled by 2^32; a quotient of
    // 2^33 or more is flagged as overflow.
    always_comb begin
        st_next[0].valid = in.valid;
        st_next[0].orig  = in.orig;
        st_next[0].zero  = in.zero;
        st_next[0].dneg  = in.dneg;
        st_next[0].aneg  = in.aneg;
        st_next[0].dmag  = in.dmag;
        for (int k = 0; k < N_ENT; k++) begin
            st_next[0].rem[k] = {in.amag[k], {SHF_W{1'b0}}};
            st_next[0].quo[k] = '0;
            st_next[0].ovf[k] = CMP_W'({in.amag[k], {SHF_W{1'b0}}})
                              >= {in.dmag, {QUO_W{1'b0}}};
        end
    end

    // One trial subtraction per lane in each stage, most significant bit first.
    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int SH = QUO_W - 1 - j;
        always_comb begin
            logic [CMP_W-1:0] dsh;
            st_next[j+1] = st_reg[j];
            dsh = CMP_W'(st_reg[j].dmag) << SH;
            for (int k = 0; k < N_ENT; k++) begin
                if (CMP_W'(st_reg[j].rem[k]) >= dsh) begin
                    st_next[j+1].rem[k]     = st_reg[j].rem[k] - dsh[NUM_W-1:0];
                    st_next[j+1].quo[k][SH] = 1'b1;
                end
            end
        end
    end

    // Stage registers; only the valid bit is cleared by reset.
    for (genvar j = 0; j <= QUO_W; j++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[j].valid <= 1'b0;
            end else if (en) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    assign out = st_reg[QUO_W];

endmodule

[hdl/mi3_skid.sv]
// Output register plus a skid entry; the pipeline stalls once backpressure fills it.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_skid (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          en,
    input  logic          in_valid,
    input  mi3_pkg::out_t in_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mi3_pkg::out_t m_data,
    output logic          full
);
    import mi3_pkg::*;

    logic main_v_reg, skid_v_reg;
    out_t main_reg, skid_reg;

    // The pipeline advances whenever the skid entry is free.
    assign en      = !skid_v_reg;
    assign m_valid = main_v_reg;
    assign m_data  = main_reg;
    assign full    = skid_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            // Main is full; drain the skid entry on a transfer.
            if (m_ready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (!main_v_reg || m_ready) begin
            main_v_reg <= in_valid;
        end else if (in_valid) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_ready) begin
                main_reg <= skid_reg;
            end
        end else if (!main_v_reg || m_ready) begin
            main_reg <= in_data;
        end else begin
            skid_reg <= in_data;
        end
    end

endmodule

[hdl/matrix3x3_inverse.sv]
// Top level of the 3x3 matrix inverse in signed Q16.16.
// Depends on mi3_pkg, mi3_front, mi3_div, mi3_skid and matrix3x3_inverse_assert.svh.
//
// Accepts one matrix per clock while s_ready is high and returns its inverse
// through seven stages of products and determinant, a 34-stage restoring
// divider that, after its entry stage, yields one quotient bit per stage for all
// nine entries, and the output register. An output skid entry lets a transfer
// complete while a result waits; s_ready falls only after that entry has filled
// and rises once it drains. A zero determinant returns the input with singular
// set; quotients outside Q16.16 clip and set saturated.
`timescale 1ns / 1ps
module matrix3x3_inverse (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  mi3_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output mi3_pkg::out_t m_data
);
    import mi3_pkg::*;
    `include "matrix3x3_inverse_assert.svh"

    logic    en;
    logic    skid_full;
    front_t  front;
    dstage_t dfin;
    out_t    res;
    mat_t    rmat;
    logic [N_ENT-1:0] sat;

    assign s_ready = en;

    mi3_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out      (front)
    );

    mi3_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in      (front),
        .out     (dfin)
    );

    // Sign and clip each quotient; pass the input back for a singular matrix.
    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            if (dfin.aneg[k] != dfin.dneg) begin
                sat[k]  = dfin.ovf[k] || (dfin.quo[k] > QUO_W'(33'h0_8000_0000));
                rmat[k] = sat[k] ? ent_t'(32'h8000_0000) : -dfin.quo[k][ENT_W-1:0];
            end else begin
                sat[k]  = dfin.ovf[k] || (dfin.quo[k] > QUO_W'(33'h0_7FFF_FFFF));
                rmat[k] = sat[k] ? ent_t'(32'h7FFF_FFFF) : dfin.quo[k][ENT_W-1:0];
            end
        end
        if (dfin.zero) begin
            rmat = dfin.orig;
        end
        res.r00 = rmat[0]; res.r01 = rmat[1]; res.r02 = rmat[2];
        res.r10 = rmat[3]; res.r11 = rmat[4]; res.r12 = rmat[5];
        res.r20 = rmat[6]; res.r21 = rmat[7]; res.r22 = rmat[8];
        res.singular  = dfin.zero;
        res.saturated = !dfin.zero && (|sat);
    end

    mi3_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dfin.valid),
        .in_data  (res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .full     (skid_full)
    );

    // A held skid entry always sits behind a valid output register.
    `MI3_ASSERT_IMP(a_skid_behind_main, aclk, aresetn, skid_full, m_valid)
    // A singular result never reports clipping.
    `MI3_ASSERT_IMP(a_singular_no_sat, aclk, aresetn, m_valid && m_data.singular, !m_data.saturated)
    // Input backpressure clears in the cycle after an output transfer.
    `MI3_ASSERT_NXT(a_ready_recovers, aclk, aresetn, m_valid && m_ready && !s_ready, s_ready)

endmodule

[test/mi3_checker.sv]
// Checker for the 3x3 matrix inverse: watches both channels, computes each inverse, compares.
// Depends on mi3_pkg for the payload structs.
`timescale 1ns / 1ps
module mi3_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  mi3_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  mi3_pkg::out_t m_data,
    output int            errors,
    output int            pending
);
    import mi3_pkg::*;

    out_t inv_q[$];

    // Exact inverse: adjugate over Sarrus determinant, truncated, then clipped.
    function automatic out_t invert(input in_t d);
        logic signed [31:0]  e [9];
        logic signed [127:0] det, adj, t;
        logic [127:0]        dmag, amag, num, quo;
        logic signed [31:0]  r [9];
        logic                dneg, aneg, sat;
        out_t                o;
        e[0] = d.m00; e[1] = d.m01; e[2] = d.m02;
        e[3] = d.m10; e[4] = d.m11; e[5] = d.m12;
        e[6] = d.m20; e[7] = d.m21; e[8] = d.m22;
        det = 0;
        for (int k = 0; k < 6; k++) begin
            t = 128'(e[DET_IDX[k][0]]) * 128'(e[DET_IDX[k][1]]) * 128'(e[DET_IDX[k][2]]);
            det = (k < 3) ? det + t : det - t;
        end
        sat = 1'b0;
        if (det == 0) begin
            o = '0;
            o.r00 = d.m00; o.r01 = d.m01; o.r02 = d.m02;
            o.r10 = d.m10; o.r11 = d.m11; o.r12 = d.m12;
            o.r20 = d.m20; o.r21 = d.m21; o.r22 = d.m22;
            o.singular = 1'b1;
            return o;
        end
        dneg = det[127];
        dmag = dneg ? -det : det;
        for (int k = 0; k < 9; k++) begin
            adj = 128'(e[ADJ_IDX[k][0]]) * 128'(e[ADJ_IDX[k][1]])
                - 128'(e[ADJ_IDX[k][2]]) * 128'(e[ADJ_IDX[k][3]]);
            aneg = adj[127];
            amag = aneg ? -adj : adj;
            num = amag << 32;
            quo = num / dmag;
            if (aneg != dneg) begin
                if (quo > 128'h8000_0000) begin r[k] = 32'h8000_0000; sat = 1'b1; end
                else r[k] = 32'(-quo);
            end else begin
                if (quo > 128'h7FFF_FFFF) begin r[k] = 32'h7FFF_FFFF; sat = 1'b1; end
                else r[k] = quo[31:0];
            end
        end
        o.r00 = r[0]; o.r01 = r[1]; o.r02 = r[2];
        o.r10 = r[3]; o.r11 = r[4]; o.r12 = r[5];
        o.r20 = r[6]; o.r21 = r[7]; o.r22 = r[8];
        o.singular = 1'b0;
        o.saturated = sat;
        return o;
    endfunction

    assign pending = inv_q.size();

    // Record each input transfer and check each result transfer.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            errors <= 0;
        end else begin
            if (s_valid && s_ready) inv_q.push_back(invert(s_data));
            if (m_valid && m_ready) begin
                if (inv_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result %h", m_data);
                    errors <= errors + 1;
                end else begin
                    want = inv_q.pop_front();
                    if (want !== m_data) begin
                        if (errors < 10) $display("mismatch: expected %h actual %h", want, m_data);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

[test/tb.sv]
// Testbench top for matrix3x3_inverse: clock, reset, stimulus and verdict.
// Depends on mi3_pkg, the block and mi3_checker.
`timescale 1ns / 1ps
module tb;
    import mi3_pkg::*;

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready;
    in_t  s_data;
    out_t m_data;
    int   errors, pending;
    bit   calm;

    matrix3x3_inverse DUT (.*);
    mi3_checker chk (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

    function automatic ent_t pick_ent();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return ent_t'($signed($urandom_range(0, 8))) <<< 16;
            4: return $urandom;
            default: return ent_t'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic in_t random_matrix();
        in_t d;
        d = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            d.m00 = pick_ent(); d.m01 = pick_ent(); d.m02 = pick_ent();
            d.m10 = pick_ent(); d.m11 = pick_ent(); d.m12 = pick_ent();
            d.m20 = pick_ent(); d.m21 = pick_ent(); d.m22 = pick_ent();
        end
        // Copied rows make some matrices singular.
        if ($urandom_range(0, 9) == 0) {d.m20, d.m21, d.m22} = {d.m00, d.m01, d.m02};
        return d;
    endfunction

    // Offer one matrix and hold it until the transfer.
    task automatic send(input in_t d);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Receiver stalls in random bursts until the quiet tail of the run.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    initial begin
        in_t d;
        int  waited;
        calm = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity, zero, extremes, singular, scaled and clipping cases.
        d = '0; d.m00 = 32'h1_0000; d.m11 = 32'h1_0000; d.m22 = 32'h1_0000; send(d);
        send('0);
        send({9{32'h8000_0000}});
        send({9{32'h7FFF_FFFF}});
        send({9{32'hFFFF_FFFF}});
        d = '0; d.m00 = 32'h8000_0000; d.m11 = 32'h8000_0000; d.m22 = 32'h8000_0000; send(d);
        d = '0; d.m00 = 32'h7FFF_FFFF; d.m11 = 32'h7FFF_FFFF; d.m22 = 32'h7FFF_FFFF; send(d);
        d = '0; d.m00 = 1; d.m11 = 1; d.m22 = 1; send(d);
        d = '0; d.m00 = -1; d.m11 = 1; d.m22 = 1; send(d);
        d = '0; d.m00 = 32'h2_0000; d.m11 = 32'hFFFE_0000; d.m22 = 32'h4_0000; send(d);
        d = '0; d.m02 = 32'h1_0000; d.m10 = 32'h1_0000; d.m21 = 32'h1_0000; send(d);
        d = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000,
             32'h6_0000, 32'h7_0000, 32'h8_0000, 32'h9_0000}; send(d);
        d = {32'h2_0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h3_0000,
             32'h0, 32'h0, 32'h1_0000, 32'h4_0000}; send(d);
        d = '0; d.m00 = 32'h8000_0000; d.m11 = 32'h7FFF_FFFF; d.m22 = 1; send(d);
        d = '0; d.m00 = 32'h10; d.m11 = 32'h8000; d.m22 = 32'h7FFF_FFFF; send(d);

        // Hold off until everything in flight has come back.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        for (int i = 0; i < 1700; i++) begin
            if (i == 1500) calm = 1;
            send(random_matrix());
        end
        s_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
